// ----- sv/tscw_pkg.sv -----
// Package for the TCP sender congestion window block.
// Types, constants and codes shared by the controller, datapath and top level.
package tscw_pkg;

	localparam int WindowDepth = 64;
	localparam int IdxW = $clog2(WindowDepth);
	localparam int CntW = $clog2(WindowDepth + 1);
	localparam int CwndCap = (WindowDepth < 127) ? WindowDepth : 127;

	typedef enum logic [1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_SEND    = 2'd1,
		ACT_RESEND  = 2'd2,
		ACT_REFUSED = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_RTO_INIT = 2'd0,
		REG_RTO_LIM  = 2'd1,
		REG_SST_INIT = 2'd2,
		REG_DUP_LIM  = 2'd3
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RETIRE,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic retire;
		logic finish_ack;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ack_new;
		logic more;
		logic out_full;
	} stat_t;

	function automatic logic seq_above(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

endpackage

// ----- sv/tcp_sender_congestion_window_top.sv -----
// Top level of the TCP sender congestion window block: APB register port,
// controller and datapath. Depends on tscw_pkg, tscw_ctrl and tscw_dp.
// A transaction that retires no segment passes through the read, evaluate and
// output states; an ack that retires segments walks them one at a time through
// the ring memory's single read port, then finds the first segment still held
// and closes the ack. A result stays in the output register until taken; the
// next transaction is accepted no earlier than the edge at which the result
// is taken.
module tcp_sender_congestion_window_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] seg_length,
	input  logic [31:0] ack_number,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [31:0] out_seqno,
	output logic [15:0] out_length,
	output logic [6:0]  cwnd_now,
	output logic [6:0]  ssthresh_now,
	output logic [19:0] rto_now_ms,
	output logic [6:0]  outstanding,
	output logic        timer_on
);
	import tscw_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  busy, in_fire, cfg_we;
	logic [19:0] rto_i, rto_l;
	logic [6:0]  sst_i;
	logic [2:0]  dup_l;

	assign pready = 1'b1;
	assign in_ready = !busy && (!out_valid || out_ready);
	assign in_fire = in_valid && in_ready;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		unique case (reg_t'(paddr[3:2]))
			REG_RTO_INIT: prdata = {12'd0, rto_i};
			REG_RTO_LIM:  prdata = {12'd0, rto_l};
			REG_SST_INIT: prdata = {25'd0, sst_i};
			REG_DUP_LIM:  prdata = {29'd0, dup_l};
			default:      prdata = '0;
		endcase
	end

	tscw_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .stat, .cmd, .busy
	);

	tscw_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .op, .seg_length, .ack_number, .now_ms,
		.cfg_we, .cfg_idx(paddr[3:2]), .cfg_data(pwdata),
		.rto_initial_q(rto_i), .rto_limit_q(rto_l), .sst_initial_q(sst_i),
		.dup_limit_q(dup_l), .out_valid, .out_ready, .action, .out_seqno,
		.out_length, .cwnd_now, .ssthresh_now, .rto_now_ms, .outstanding, .timer_on
	);

endmodule

// ----- sv/tscw_ctrl.sv -----
// Controller state machine for the TCP sender congestion window block.
// Depends on tscw_pkg; drives commands to tscw_dp.
module tscw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  tscw_pkg::stat_t  stat,
	output tscw_pkg::cmd_t   cmd,
	output logic             busy
);
	import tscw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_READ;
			ST_READ:   state_d = ST_EVAL;
			ST_EVAL:   state_d = stat.ack_new ? ST_RETIRE : ST_OUT;
			ST_RETIRE: state_d = stat.more ? ST_RETIRE : ST_DONE;
			ST_DONE:   state_d = ST_OUT;
			ST_OUT:    if (!stat.out_full) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		cmd.load = (state_q == ST_IDLE) && in_fire;
		unique case (state_q)
			ST_READ:   cmd.rd = 1'b1;
			ST_EVAL:   cmd.eval = 1'b1;
			ST_RETIRE: begin
				cmd.retire = stat.more;
				cmd.rd = stat.more;
			end
			ST_DONE:   cmd.finish_ack = 1'b1;
			ST_OUT:    cmd.emit = !stat.out_full;
			default:   ;
		endcase
	end

endmodule

// ----- sv/tscw_dp.sv -----
// Datapath for the TCP sender congestion window block: segment ring memory,
// window, RTT and RTO registers. Depends on tscw_pkg; commanded by tscw_ctrl.
module tscw_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tscw_pkg::cmd_t               cmd,
	output tscw_pkg::stat_t              stat,
	input  logic [1:0]                   op,
	input  logic [15:0]                  seg_length,
	input  logic [31:0]                  ack_number,
	input  logic [31:0]                  now_ms,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_idx,
	input  logic [31:0]                  cfg_data,
	output logic [19:0]                  rto_initial_q,
	output logic [19:0]                  rto_limit_q,
	output logic [6:0]                   sst_initial_q,
	output logic [2:0]                   dup_limit_q,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   action,
	output logic [31:0]                  out_seqno,
	output logic [15:0]                  out_length,
	output logic [6:0]                   cwnd_now,
	output logic [6:0]                   ssthresh_now,
	output logic [19:0]                  rto_now_ms,
	output logic [6:0]                   outstanding,
	output logic                         timer_on
);
	import tscw_pkg::*;

	logic [31:0] mem_seq [WindowDepth];
	logic [15:0] mem_len [WindowDepth];
	logic [31:0] mem_time [WindowDepth];
	logic        mem_rs  [WindowDepth];

	logic [31:0] rd_seq_q, rd_time_q;
	logic [15:0] rd_len_q;
	logic        rd_rs_q;

	logic [1:0]  op_q;
	logic [31:0] ack_q, now_q;

	logic [IdxW-1:0] head_q;
	logic [CntW-1:0] held_q;
	logic [31:0]     next_seq_q;
	logic [6:0]      cwnd_q, sst_q, avoid_q;
	logic [2:0]      dup_q;
	logic [23:0]     srtt_q;
	logic [19:0]     rto_q;
	logic [31:0]     last_to_q;
	logic            timer_q;
	logic            ovalid_q;

	logic [IdxW-1:0] rd_addr;
	logic [IdxW-1:0] wr_addr;
	logic            above, is_dup;
	logic [6:0]      half, cut_sst;
	logic [2:0]      lim, dup_inc;
	logic [31:0]     rtt;
	logic [24:0]     srtt_sum;
	logic [23:0]     srtt_new;
	logic [20:0]     rto_dbl;
	logic            send_ok;
	logic [6:0]      cwnd_g, avoid_g, avoid_inc;

	assign rd_addr = cmd.retire ? (head_q + IdxW'(1)) : head_q;
	assign wr_addr = head_q + held_q[IdxW-1:0];
	assign above = seq_above(ack_q, rd_seq_q);
	assign is_dup = (ack_q == rd_seq_q);
	assign half = {1'b0, cwnd_q[6:1]};
	assign cut_sst = (half > 7'd2) ? ((half > 7'(CwndCap)) ? 7'(CwndCap) : half) : 7'd2;
	assign lim = (dup_limit_q == 3'd0) ? 3'd1 : dup_limit_q;
	assign dup_inc = (dup_q < 3'd7) ? dup_q + 3'd1 : dup_q;
	assign rtt = now_q - rd_time_q;
	assign srtt_sum = {1'b0, srtt_q - {3'd0, srtt_q[23:3]}} + {1'b0, rtt[23:0]};
	assign srtt_new = (srtt_sum[24] || (rtt[31:24] != 8'd0)) ? 24'hFFFFFF : srtt_sum[23:0];
	assign rto_dbl = {rto_q, 1'b0};
	assign send_ok = ({1'b0, held_q} < {1'b0, cwnd_q}) && (held_q < CntW'(WindowDepth));
	assign avoid_inc = avoid_q + 7'd1;

	always_comb begin
		cwnd_g = cwnd_q;
		avoid_g = avoid_q;
		if (cwnd_q < sst_q) begin
			if (cwnd_q < 7'(CwndCap)) cwnd_g = cwnd_q + 7'd1;
		end else begin
			avoid_g = avoid_inc;
			if (avoid_inc >= cwnd_q) begin
				avoid_g = '0;
				if (cwnd_q < 7'(CwndCap)) cwnd_g = cwnd_q + 7'd1;
			end
		end
	end

	assign stat.ack_new = (op_q == OP_ACK) && (held_q != '0) && above;
	assign stat.more = (held_q != '0) && above;
	assign stat.out_full = ovalid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load && op == OP_SEND && send_ok) begin
			mem_seq[wr_addr]  <= next_seq_q;
			mem_len[wr_addr]  <= seg_length;
			mem_time[wr_addr] <= now_ms;
			mem_rs[wr_addr]   <= 1'b0;
		end else if (cmd.eval && op_q == OP_TIMEOUT && held_q != '0) begin
			mem_rs[head_q] <= 1'b1;
		end else if (cmd.eval && op_q == OP_ACK && held_q != '0 && !above && is_dup
			&& dup_inc >= lim) begin
			mem_rs[head_q] <= 1'b1;
		end
		if (cmd.rd) begin
			rd_seq_q  <= mem_seq[rd_addr];
			rd_len_q  <= mem_len[rd_addr];
			rd_time_q <= mem_time[rd_addr];
			rd_rs_q   <= mem_rs[rd_addr];
		end
		if (cmd.load) begin
			op_q  <= op;
			ack_q <= ack_number;
			now_q <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rto_initial_q <= 20'd3000;
			rto_limit_q <= 20'd8000;
			sst_initial_q <= 7'd64;
			dup_limit_q <= 3'd3;
			head_q <= '0;
			held_q <= '0;
			next_seq_q <= '0;
			cwnd_q <= 7'd1;
			sst_q <= (7'd64 > 7'(CwndCap)) ? 7'(CwndCap) : 7'd64;
			avoid_q <= '0;
			dup_q <= '0;
			srtt_q <= '0;
			rto_q <= 20'd3000;
			last_to_q <= '0;
			timer_q <= 1'b0;
			ovalid_q <= 1'b0;
			action <= ACT_NONE;
			out_seqno <= '0;
			out_length <= '0;
		end else begin
			if (out_ready) ovalid_q <= 1'b0;
			if (cfg_we) begin
				unique case (reg_t'(cfg_idx))
					REG_RTO_INIT: begin
						rto_initial_q <= cfg_data[19:0];
						rto_q <= cfg_data[19:0];
					end
					REG_RTO_LIM: rto_limit_q <= cfg_data[19:0];
					REG_SST_INIT: begin
						sst_initial_q <= cfg_data[6:0];
						sst_q <= (cfg_data[6:0] < 7'd2) ? 7'd2 :
							(cfg_data[6:0] > 7'(CwndCap)) ? 7'(CwndCap) : cfg_data[6:0];
					end
					REG_DUP_LIM: dup_limit_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				action <= ACT_NONE;
				out_seqno <= '0;
				out_length <= '0;
				if (op == OP_SEND) begin
					if (send_ok) begin
						action <= ACT_SEND;
						out_seqno <= next_seq_q;
						out_length <= seg_length;
						next_seq_q <= next_seq_q + {16'd0, seg_length};
						held_q <= held_q + CntW'(1);
						timer_q <= 1'b1;
					end else begin
						action <= ACT_REFUSED;
					end
				end
			end
			if (cmd.eval) begin
				if (op_q == OP_ACK && held_q != '0) begin
					if (above) begin
						if (!rd_rs_q) begin
							srtt_q <= srtt_new;
							rto_q <= (srtt_new[23:22] != 2'd0) ? 20'hFFFFF : srtt_new[21:2];
						end
					end else if (is_dup) begin
						dup_q <= dup_inc;
						if (dup_inc >= lim) begin
							sst_q <= cut_sst;
							cwnd_q <= 7'd1;
							avoid_q <= '0;
							action <= ACT_RESEND;
							out_seqno <= rd_seq_q;
							out_length <= rd_len_q;
							dup_q <= '0;
						end
					end
				end else if (op_q == OP_TIMEOUT) begin
					sst_q <= cut_sst;
					cwnd_q <= 7'd1;
					avoid_q <= '0;
					if (held_q != '0) begin
						action <= ACT_RESEND;
						out_seqno <= rd_seq_q;
						out_length <= rd_len_q;
						if (last_to_q == rd_seq_q)
							rto_q <= (rto_dbl < {1'b0, rto_limit_q}) ? rto_dbl[19:0] : rto_limit_q;
						last_to_q <= rd_seq_q;
					end
					timer_q <= (held_q != '0);
				end
			end
			if (cmd.retire) begin
				cwnd_q <= cwnd_g;
				avoid_q <= avoid_g;
				head_q <= head_q + IdxW'(1);
				held_q <= held_q - CntW'(1);
			end
			if (cmd.finish_ack) begin
				dup_q <= '0;
				timer_q <= (held_q != '0);
			end
			if (cmd.emit) ovalid_q <= 1'b1;
		end
	end

	assign out_valid = ovalid_q;
	assign cwnd_now = cwnd_q;
	assign ssthresh_now = sst_q;
	assign rto_now_ms = rto_q;
	assign outstanding = 7'(held_q);
	assign timer_on = timer_q;

endmodule

// ----- sv/tscw_checker.sv -----
// Port-level checker for the TCP sender congestion window block.
// Depends on tscw_pkg; bound to tcp_sender_congestion_window_top.
module tscw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] action,
	input logic [6:0] cwnd_now,
	input logic [6:0] outstanding,
	input logic [6:0] ssthresh_now
);
	import tscw_pkg::*;

	a_cwnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cwnd_now != 7'd0 && cwnd_now <= 7'(CwndCap)) else $error("cwnd out of range");
	a_sst_range: assert property (@(posedge clk) disable iff (!arst_n)
		ssthresh_now >= 7'd2) else $error("ssthresh below two");
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding <= 7'(WindowDepth)) else $error("outstanding too large");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action))
		else $error("result dropped");
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !(out_valid && !out_ready))
		else $error("transaction taken while result waits");
endmodule

bind tcp_sender_congestion_window_top tscw_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .action,
	.cwnd_now, .outstanding, .ssthresh_now
);

// ----- tb/tcp_sender_congestion_window_checker.sv -----
// Checker for the TCP sender congestion window block: predicts each result
// from accepted transactions and register writes. Depends on tscw_pkg.
module tcp_sender_congestion_window_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] seg_length,
	input  logic [31:0] ack_number,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  action,
	input  logic [31:0] out_seqno,
	input  logic [15:0] out_length,
	input  logic [6:0]  cwnd_now,
	input  logic [6:0]  ssthresh_now,
	input  logic [19:0] rto_now_ms,
	input  logic [6:0]  outstanding,
	input  logic        timer_on,
	output int          errors,
	output int          pending,
	output int          resends,
	output int          refusals
);
	import tscw_pkg::*;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] seqno;
		logic [15:0] len;
		logic [6:0]  cwnd;
		logic [6:0]  sst;
		logic [19:0] rto;
		logic [6:0]  held;
		logic        timer;
	} window_result_t;

	window_result_t result_q[$];

	logic [31:0] ring_seq[WindowDepth];
	logic [15:0] ring_len[WindowDepth];
	logic [31:0] ring_time[WindowDepth];
	logic        ring_resent[WindowDepth];
	int unsigned head, held, cwnd, sst, avoid, dups, srtt8, rto, last_to;
	int unsigned rto_init, rto_lim, sst_init, dup_lim;
	logic [31:0] next_seq;
	logic        timer;

	function automatic int unsigned clamp_sst(int unsigned v);
		if (v < 2) return 2;
		if (v > CwndCap) return CwndCap;
		return v;
	endfunction

	function automatic bit above(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d != 0 && !d[31];
	endfunction

	task automatic cut_window();
		int unsigned half;
		half = cwnd / 2;
		sst = clamp_sst(half > 2 ? half : 2);
		cwnd = 1;
		avoid = 0;
	endtask

	task automatic grow_window();
		if (cwnd < sst) begin
			if (cwnd < CwndCap) cwnd++;
		end else begin
			avoid++;
			if (avoid >= cwnd) begin
				avoid = 0;
				if (cwnd < CwndCap) cwnd++;
			end
		end
	endtask

	task automatic predict_window(logic [1:0] o, logic [15:0] len, logic [31:0] ackn,
			logic [31:0] now);
		window_result_t r;
		int unsigned s, lim;
		logic [31:0] rtt;
		longint unsigned v, d;
		r = '0;
		if (o == OP_SEND) begin
			if (held < cwnd && held < WindowDepth) begin
				s = (head + held) % WindowDepth;
				ring_seq[s] = next_seq;
				ring_len[s] = len;
				ring_time[s] = now;
				ring_resent[s] = 1'b0;
				r.act = ACT_SEND;
				r.seqno = next_seq;
				r.len = len;
				next_seq += {16'd0, len};
				held++;
				timer = 1'b1;
			end else begin
				r.act = ACT_REFUSED;
			end
		end else if (o == OP_ACK && held > 0) begin
			if (above(ackn, ring_seq[head])) begin
				if (!ring_resent[head]) begin
					rtt = now - ring_time[head];
					v = longint'(srtt8 - (srtt8 >> 3)) + rtt;
					srtt8 = v > 64'hFFFFFF ? 32'hFFFFFF : 32'(v);
					rto = (srtt8 >> 2) > 32'hFFFFF ? 32'hFFFFF : (srtt8 >> 2);
				end
				while (held > 0 && above(ackn, ring_seq[head])) begin
					grow_window();
					head = (head + 1) % WindowDepth;
					held--;
				end
				dups = 0;
				timer = held > 0;
			end else if (ackn == ring_seq[head]) begin
				lim = dup_lim == 0 ? 1 : dup_lim;
				if (dups < 7) dups++;
				if (dups >= lim) begin
					cut_window();
					ring_resent[head] = 1'b1;
					r.act = ACT_RESEND;
					r.seqno = ring_seq[head];
					r.len = ring_len[head];
					dups = 0;
				end
			end
		end else if (o == OP_TIMEOUT) begin
			cut_window();
			if (held > 0) begin
				ring_resent[head] = 1'b1;
				r.act = ACT_RESEND;
				r.seqno = ring_seq[head];
				r.len = ring_len[head];
				if (last_to == r.seqno) begin
					d = longint'(rto) * 2;
					rto = d < rto_lim ? 32'(d) : rto_lim;
				end
				last_to = r.seqno;
			end
			timer = held > 0;
		end
		r.cwnd = 7'(cwnd);
		r.sst = 7'(sst);
		r.rto = 20'(rto);
		r.held = 7'(held);
		r.timer = timer;
		if (r.act == ACT_RESEND) resends++;
		if (r.act == ACT_REFUSED) refusals++;
		result_q.push_back(r);
	endtask

	task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t %s: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_result_t e;
		if (!arst_n) begin
			result_q.delete();
			errors = 0;
			resends = 0;
			refusals = 0;
			rto_init = 3000;
			rto_lim = 8000;
			sst_init = 64;
			dup_lim = 3;
			head = 0;
			held = 0;
			next_seq = 0;
			cwnd = 1;
			sst = clamp_sst(64);
			avoid = 0;
			dups = 0;
			srtt8 = 0;
			rto = 3000;
			last_to = 0;
			timer = 1'b0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_t'(paddr[3:2]))
					REG_RTO_INIT: begin
						rto_init = 32'(pwdata[19:0]);
						rto = rto_init;
					end
					REG_RTO_LIM: rto_lim = 32'(pwdata[19:0]);
					REG_SST_INIT: begin
						sst_init = 32'(pwdata[6:0]);
						sst = clamp_sst(sst_init);
					end
					REG_DUP_LIM: dup_lim = 32'(pwdata[2:0]);
				endcase
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result: actual action %0d", $time, action);
				end else begin
					e = result_q.pop_front();
					compare_field("action", e.act, action);
					compare_field("out_seqno", e.seqno, out_seqno);
					compare_field("out_length", e.len, out_length);
					compare_field("cwnd_now", e.cwnd, cwnd_now);
					compare_field("ssthresh_now", e.sst, ssthresh_now);
					compare_field("rto_now_ms", e.rto, rto_now_ms);
					compare_field("outstanding", e.held, outstanding);
					compare_field("timer_on", e.timer, timer_on);
				end
			end
			if (in_valid && in_ready)
				predict_window(op, seg_length, ack_number, now_ms);
		end
	end

	assign pending = result_q.size();

endmodule

// ----- tb/tcp_sender_congestion_window_top_test.sv -----
// Testbench top for the TCP sender congestion window block: clock, reset,
// register writes and stimulus. Depends on tscw_pkg and the checker module.
module tcp_sender_congestion_window_top_test;
	import tscw_pkg::*;

	localparam int StallLimit = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  op = OP_NOP;
	logic [15:0] seg_length = '0;
	logic [31:0] ack_number = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  action;
	logic [31:0] out_seqno;
	logic [15:0] out_length;
	logic [6:0]  cwnd_now, ssthresh_now, outstanding;
	logic [19:0] rto_now_ms;
	logic        timer_on;
	int          errors, pending, resends, refusals;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	int          items = 0, idle_cycles = 0;
	logic [31:0] clock_ms = 0;
	logic [31:0] sent_seq[$];
	logic [31:0] next_seq = 0;

	always #4 clk = ~clk;

	tcp_sender_congestion_window_top dut (.*);

	tcp_sender_congestion_window_checker checker_i (.*);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= StallLimit) begin
			$display("tcp_sender_congestion_window_top: mismatch");
			$finish;
		end
	end

	task automatic write_reg(reg_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// drives one transaction and waits until it is accepted
	task automatic issue(logic [1:0] o, logic [15:0] len, logic [31:0] ackn);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		clock_ms = clock_ms + $urandom_range(40);
		in_valid <= 1;
		op <= o;
		seg_length <= len;
		ack_number <= ackn;
		now_ms <= ($urandom_range(31) == 0) ? {$urandom} : clock_ms;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items++;
	endtask

	function automatic logic [31:0] pick_ack();
		int k;
		k = $urandom_range(9);
		if (sent_seq.size() == 0 || k == 0) return $urandom;
		if (k < 4) return sent_seq[0];
		return sent_seq[$urandom_range(sent_seq.size() - 1)] + $urandom_range(1);
	endfunction

	task automatic random_op();
		int k;
		logic [15:0] len;
		k = $urandom_range(99);
		if (k < 45) begin
			len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
			sent_seq.push_back(next_seq);
			if (sent_seq.size() > 64) void'(sent_seq.pop_front());
			next_seq = next_seq + {16'd0, len};
			issue(OP_SEND, len, '0);
		end else if (k < 85) begin
			issue(OP_ACK, 16'($urandom), pick_ack());
		end else if (k < 95) begin
			issue(OP_TIMEOUT, 16'($urandom), $urandom);
		end else begin
			issue(OP_NOP, 16'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1;

		// directed: refusal, zero length, dup acks, timeouts, wrap compare
		issue(OP_TIMEOUT, 0, 0);
		issue(OP_ACK, 0, 5);
		issue(OP_SEND, 16'hFFFF, 0);
		issue(OP_SEND, 10, 0);
		issue(OP_ACK, 0, 32'hFFFF_FFFF);
		issue(OP_ACK, 0, 0);
		issue(OP_ACK, 0, 0);
		issue(OP_ACK, 0, 0);
		issue(OP_TIMEOUT, 0, 0);
		issue(OP_TIMEOUT, 0, 0);
		issue(OP_TIMEOUT, 0, 0);
		issue(OP_ACK, 0, 32'h8000_0000);
		issue(OP_ACK, 0, 32'h0001_0000);
		issue(OP_SEND, 0, 0);
		issue(OP_SEND, 100, 0);
		issue(OP_ACK, 0, 32'h0001_0064);
		issue(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF);
		next_seq = 32'h0001_0064;
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				3: begin send_idle_pct = 24; recv_stall_pct = 24; end
				4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase
			write_reg(REG_RTO_INIT, phase[0] ? 32'hFFFFF : $urandom_range(1, 5000));
			write_reg(REG_RTO_LIM, phase == 2 ? 32'd1 : (phase == 3 ? 32'hFFFFF : 32'd9000));
			write_reg(REG_SST_INIT,
				phase == 1 ? 32'd0 : (phase == 2 ? 32'd127 : $urandom_range(2, 64)));
			write_reg(REG_DUP_LIM, phase);
			for (int i = 0; i < 100; i++) begin
				random_op();
				if (i == 50) drain();
			end
			drain();
		end
		write_reg(REG_DUP_LIM, 7);

		$display("Ran %0d transactions over five register settings and idling mixes;", items);
		$display("%0d retransmissions and %0d refused sends seen.", resends, refusals);
		if (errors == 0)
			$display("tcp_sender_congestion_window_top: match");
		else
			$display("tcp_sender_congestion_window_top: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tscw_pkg.sv
sv/tscw_ctrl.sv
sv/tscw_dp.sv
sv/tcp_sender_congestion_window_top.sv
sv/tscw_checker.sv
tb/tcp_sender_congestion_window_checker.sv
tb/tcp_sender_congestion_window_top_test.sv
